// ----- hw/rtl/rvx_pkg.sv -----
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared constants, codes and types of the register VM execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rvx_pkg;

  localparam int REGS_DEF   = 256;
  localparam int LOCALS_DEF = 64;
  localparam int FRAMES_DEF = 16;
  localparam int CFG_AW     = 3;

  localparam logic [4:0] ACT_MOVIMM    = 5'd0;
  localparam logic [4:0] ACT_MOVREG    = 5'd1;
  localparam logic [4:0] ACT_MOVCONST  = 5'd2;
  localparam logic [4:0] ACT_ADD       = 5'd3;
  localparam logic [4:0] ACT_SUB       = 5'd4;
  localparam logic [4:0] ACT_MUL       = 5'd5;
  localparam logic [4:0] ACT_DIV       = 5'd6;
  localparam logic [4:0] ACT_MOD       = 5'd7;
  localparam logic [4:0] ACT_CALL      = 5'd8;
  localparam logic [4:0] ACT_RET       = 5'd9;
  localparam logic [4:0] ACT_HALT      = 5'd10;
  localparam logic [4:0] ACT_JUMP      = 5'd11;
  localparam logic [4:0] ACT_GE        = 5'd12;
  localparam logic [4:0] ACT_LT        = 5'd13;
  localparam logic [4:0] ACT_LE        = 5'd14;
  localparam logic [4:0] ACT_GT        = 5'd15;
  localparam logic [4:0] ACT_EQ        = 5'd16;
  localparam logic [4:0] ACT_NE        = 5'd17;
  localparam logic [4:0] ACT_IFTRUE    = 5'd18;
  localparam logic [4:0] ACT_IFFALSE   = 5'd19;
  localparam logic [4:0] ACT_FUNCBEGIN = 5'd20;
  localparam logic [4:0] ACT_FUNCEND   = 5'd21;
  localparam logic [4:0] ACT_LOCALGET  = 5'd22;
  localparam logic [4:0] ACT_LOCALSET  = 5'd23;
  localparam logic [4:0] ACT_AND       = 5'd24;
  localparam logic [4:0] ACT_OR        = 5'd25;
  localparam logic [4:0] ACT_EXTCALL   = 5'd26;
  localparam logic [4:0] ACT_DEC       = 5'd27;
  localparam logic [4:0] ACT_NOP       = 5'd28;

  localparam logic [3:0] K_ALU    = 4'd0;
  localparam logic [3:0] K_MUL    = 4'd1;
  localparam logic [3:0] K_DIV    = 4'd2;
  localparam logic [3:0] K_CALL   = 4'd3;
  localparam logic [3:0] K_RET    = 4'd4;
  localparam logic [3:0] K_HALT   = 4'd5;
  localparam logic [3:0] K_JUMP   = 4'd6;
  localparam logic [3:0] K_BRT    = 4'd7;
  localparam logic [3:0] K_BRF    = 4'd8;
  localparam logic [3:0] K_FBEGIN = 4'd9;
  localparam logic [3:0] K_FEND   = 4'd10;
  localparam logic [3:0] K_LGET   = 4'd11;
  localparam logic [3:0] K_LSET   = 4'd12;
  localparam logic [3:0] K_EXT    = 4'd13;
  localparam logic [3:0] K_NOP    = 4'd14;
  localparam logic [3:0] K_UNSUP  = 4'd15;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_HALTED   = 3'd1;
  localparam logic [2:0] ST_DIVZERO  = 3'd2;
  localparam logic [2:0] ST_CALLOVF  = 3'd3;
  localparam logic [2:0] ST_RETUNF   = 3'd4;
  localparam logic [2:0] ST_EXTCALL  = 3'd5;
  localparam logic [2:0] ST_UNSUP    = 3'd6;
  localparam logic [2:0] ST_BADFRAME = 3'd7;

  typedef struct packed {
    logic [4:0]  action;
    logic [3:0]  kind;
    logic [7:0]  dst;
    logic [7:0]  src_a;
    logic [7:0]  src_b;
    logic [63:0] imm;
    logic [31:0] target;
    logic [3:0]  fsel;
    logic [5:0]  lidx;
    logic        lidx_ok;
    logic [5:0]  argn;
    logic [15:0] svc;
  } op_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
    logic [63:0] rem;
  } div_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rvx_req_if.sv -----
// ----------------------------------------------------------------------------
// rvx_req_if
// Instruction channel: one decoded instruction per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rvx_req_if;
  logic               valid;
  logic               ready;
  logic [4:0]         action;
  logic [7:0]         dest_reg;
  logic [7:0]         src_a_reg;
  logic [7:0]         src_b_reg;
  logic signed [63:0] immediate;
  logic [31:0]        target_pc;
  logic [3:0]         frame_sel;
  logic [5:0]         local_index;
  logic [5:0]         arg_count;
  logic [15:0]        service_id;

  modport source (
    output valid, action, dest_reg, src_a_reg, src_b_reg, immediate, target_pc,
           frame_sel, local_index, arg_count, service_id,
    input  ready
  );
  modport sink (
    input  valid, action, dest_reg, src_a_reg, src_b_reg, immediate, target_pc,
           frame_sel, local_index, arg_count, service_id,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/rvx_rsp_if.sv -----
// ----------------------------------------------------------------------------
// rvx_rsp_if
// Result channel: one execution result per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rvx_rsp_if;
  logic               valid;
  logic               ready;
  logic [31:0]        next_pc;
  logic [2:0]         status;
  logic signed [63:0] result_value;
  logic               result_written;
  logic [15:0]        service_out;

  modport source (
    output valid, next_pc, status, result_value, result_written, service_out,
    input  ready
  );
  modport sink (
    input  valid, next_pc, status, result_value, result_written, service_out,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/rvx_ram.sv -----
// ----------------------------------------------------------------------------
// rvx_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rvx_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rvx_front.sv -----
// ----------------------------------------------------------------------------
// rvx_front
// Accepts instruction words, reduces register indexes and classifies them.
// ----------------------------------------------------------------------------
`default_nettype none

module rvx_front #(
  parameter int REGS   = rvx_pkg::REGS_DEF,
  parameter int LOCALS = rvx_pkg::LOCALS_DEF
) (
  rvx_req_if.sink            req,
  input  wire logic          full,
  output      logic          push,
  output      rvx_pkg::op_t  push_op
);

  localparam int RIW     = $clog2(REGS);
  localparam int ARG_CAP = (LOCALS < REGS) ? LOCALS : REGS;

  logic [RIW-1:0] reg_map [256];
  logic [3:0]     kind;

  for (genvar g = 0; g < 256; g++) begin : g_map
    assign reg_map[g] = RIW'(g % REGS);
  end

  always_comb begin
    unique case (req.action) inside
      rvx_pkg::ACT_MOVIMM, rvx_pkg::ACT_MOVREG, rvx_pkg::ACT_MOVCONST,
      rvx_pkg::ACT_ADD, rvx_pkg::ACT_SUB, rvx_pkg::ACT_GE, rvx_pkg::ACT_LT,
      rvx_pkg::ACT_LE, rvx_pkg::ACT_GT, rvx_pkg::ACT_EQ, rvx_pkg::ACT_NE,
      rvx_pkg::ACT_AND, rvx_pkg::ACT_OR, rvx_pkg::ACT_DEC: kind = rvx_pkg::K_ALU;
      rvx_pkg::ACT_MUL:                   kind = rvx_pkg::K_MUL;
      rvx_pkg::ACT_DIV, rvx_pkg::ACT_MOD: kind = rvx_pkg::K_DIV;
      rvx_pkg::ACT_CALL:                  kind = rvx_pkg::K_CALL;
      rvx_pkg::ACT_RET:                   kind = rvx_pkg::K_RET;
      rvx_pkg::ACT_HALT:                  kind = rvx_pkg::K_HALT;
      rvx_pkg::ACT_JUMP:                  kind = rvx_pkg::K_JUMP;
      rvx_pkg::ACT_IFTRUE:                kind = rvx_pkg::K_BRT;
      rvx_pkg::ACT_IFFALSE:               kind = rvx_pkg::K_BRF;
      rvx_pkg::ACT_FUNCBEGIN:             kind = rvx_pkg::K_FBEGIN;
      rvx_pkg::ACT_FUNCEND:               kind = rvx_pkg::K_FEND;
      rvx_pkg::ACT_LOCALGET:              kind = rvx_pkg::K_LGET;
      rvx_pkg::ACT_LOCALSET:              kind = rvx_pkg::K_LSET;
      rvx_pkg::ACT_EXTCALL:               kind = rvx_pkg::K_EXT;
      rvx_pkg::ACT_NOP:                   kind = rvx_pkg::K_NOP;
      default:                            kind = rvx_pkg::K_UNSUP;
    endcase
  end

  always_comb begin
    push_op.action  = req.action;
    push_op.kind    = kind;
    push_op.dst     = 8'(reg_map[req.dest_reg]);
    push_op.src_a   = 8'(reg_map[req.src_a_reg]);
    push_op.src_b   = 8'(reg_map[req.src_b_reg]);
    push_op.imm     = req.immediate;
    push_op.target  = req.target_pc;
    push_op.fsel    = req.frame_sel;
    push_op.lidx    = req.local_index;
    push_op.lidx_ok = 32'(req.local_index) < LOCALS;
    push_op.argn    = (32'(req.arg_count) > ARG_CAP) ? 6'(ARG_CAP) : req.arg_count;
    push_op.svc     = req.service_id;
  end

  assign req.ready = !full;
  assign push      = req.valid && !full;

endmodule

`default_nettype wire

// ----- hw/rtl/rvx_queue.sv -----
// ----------------------------------------------------------------------------
// rvx_queue
// Two-entry queue of classified instructions between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module rvx_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire rvx_pkg::op_t push_op,
  output      logic         full,
  input  wire logic         pop,
  output      logic         not_empty,
  output      rvx_pkg::op_t head_op
);

  rvx_pkg::op_t slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign head_op   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rvx_div.sv -----
// ----------------------------------------------------------------------------
// rvx_div
// Signed 64-bit divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rvx_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output rvx_pkg::div_res_t res
);

  logic        busy;
  logic        fin;
  logic [5:0]  cnt;
  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] dvs;
  logic        neg_q;
  logic        neg_r;
  logic [63:0] rem_sh;

  assign rem_sh = {rem[62:0], quo[63]};

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend[63] ? -dividend : dividend;
      dvs   <= divisor[63] ? -divisor : divisor;
      rem   <= '0;
      neg_q <= dividend[63] ^ divisor[63];
      neg_r <= dividend[63];
      cnt   <= '0;
    end else if (busy) begin
      if (rem_sh >= dvs) begin
        rem <= rem_sh - dvs;
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[62:0], 1'b0};
      end
      cnt <= cnt + 6'd1;
    end
    if (fin) begin
      res.quo <= neg_q ? -quo : quo;
      res.rem <= neg_r ? -rem : rem;
    end
    if (rst) begin
      busy     <= 1'b0;
      fin      <= 1'b0;
      res.done <= 1'b0;
    end else begin
      res.done <= fin;
      fin      <= busy && !start && (cnt == 6'd63);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd63) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rvx_back.sv -----
// ----------------------------------------------------------------------------
// rvx_back
// Executes classified instructions against the machine state and holds the
// result word until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rvx_back #(
  parameter int REGS   = rvx_pkg::REGS_DEF,
  parameter int LOCALS = rvx_pkg::LOCALS_DEF,
  parameter int FRAMES = rvx_pkg::FRAMES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [63:0]  const_base,
  input  wire logic         q_valid,
  input  wire rvx_pkg::op_t q_op,
  output      logic         q_pop,
  rvx_rsp_if.source         rsp
);

  localparam int RIW = $clog2(REGS);
  localparam int FW  = $clog2(FRAMES + 1);
  localparam int RSW = $clog2(FRAMES);
  localparam int LAW = $clog2(FRAMES * LOCALS);
  localparam int CW  = $clog2(LOCALS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_CALL = 3'd4;
  localparam logic [2:0] S_RET  = 3'd5;
  localparam logic [2:0] S_LGET = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]        state;
  logic [31:0]       pc;
  logic [FW-1:0]     depth;
  logic              skipping;
  logic              halted;
  rvx_pkg::op_t      op;

  logic [REGS-1:0]   reg_valid;
  logic [RIW-1:0]    ra_addr;
  logic [RIW-1:0]    rb_addr;
  logic              rw_en;
  logic [63:0]       ra_q;
  logic [63:0]       rb_q;
  logic              ra_v;
  logic              rb_v;
  logic [63:0]       a_val;
  logic [63:0]       b_val;
  logic [63:0]       opa;
  logic [63:0]       opb;

  logic [31:0]       r_npc;
  logic [2:0]        r_status;
  logic [63:0]       r_val;
  logic              r_wr;
  logic [15:0]       r_sout;

  logic              o_valid;
  logic [31:0]       o_npc;
  logic [2:0]        o_status;
  logic [63:0]       o_val;
  logic              o_wr;
  logic [15:0]       o_sout;
  logic              commit_ok;

  logic [63:0]       alu_val;
  logic              active;
  logic              frame_ok;
  logic              call_ok;
  logic [LAW-1:0]    lslot;

  logic [1:0]        mul_step;
  logic [63:0]       acc;
  logic [31:0]       mul_x;
  logic [31:0]       mul_y;
  logic [63:0]       prod;
  logic [63:0]       acc_next;

  logic              div_start;
  rvx_pkg::div_res_t div_res;

  logic [CW-1:0]     cnt;
  logic [CW-1:0]     sw_slot;
  logic              sw_use;
  logic              sw_wen;
  logic [LAW-1:0]    lbase;

  logic              l_we;
  logic [LAW-1:0]    l_waddr;
  logic [63:0]       l_wdata;
  logic [63:0]       l_q;
  logic              rs_we;
  logic [31:0]       rs_q;

  assign commit_ok = !o_valid || rsp.ready;
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign active    = (state == S_EXEC) && !halted && !skipping;

  assign ra_addr = (state == S_CALL) ? RIW'(REGS - 1 - 32'(cnt)) :
                   (q_op.action == rvx_pkg::ACT_DEC) ? q_op.dst[RIW-1:0] :
                   q_op.src_a[RIW-1:0];
  assign rb_addr = q_op.src_b[RIW-1:0];
  assign rw_en   = (state == S_DONE) && commit_ok && r_wr;
  assign a_val   = ra_v ? ra_q : '0;
  assign b_val   = rb_v ? rb_q : '0;

  rvx_ram #(.WIDTH(64), .DEPTH(REGS)) u_rf_a (
    .clk(clk), .we(rw_en), .waddr(op.dst[RIW-1:0]), .wdata(r_val),
    .raddr(ra_addr), .rdata(ra_q)
  );

  rvx_ram #(.WIDTH(64), .DEPTH(REGS)) u_rf_b (
    .clk(clk), .we(rw_en), .waddr(op.dst[RIW-1:0]), .wdata(r_val),
    .raddr(rb_addr), .rdata(rb_q)
  );

  always_ff @(posedge clk) begin
    ra_v <= reg_valid[ra_addr];
    rb_v <= reg_valid[rb_addr];
    if (rst) begin
      reg_valid <= '0;
    end else if (rw_en) begin
      reg_valid[op.dst[RIW-1:0]] <= 1'b1;
    end
  end

  always_comb begin
    case (op.action)
      rvx_pkg::ACT_MOVIMM:   alu_val = op.imm;
      rvx_pkg::ACT_MOVREG:   alu_val = a_val;
      rvx_pkg::ACT_MOVCONST: alu_val = const_base + op.imm;
      rvx_pkg::ACT_ADD:      alu_val = a_val + b_val;
      rvx_pkg::ACT_SUB:      alu_val = a_val - b_val;
      rvx_pkg::ACT_GE:       alu_val = {63'd0, $signed(a_val) >= $signed(b_val)};
      rvx_pkg::ACT_LT:       alu_val = {63'd0, $signed(a_val) < $signed(b_val)};
      rvx_pkg::ACT_LE:       alu_val = {63'd0, $signed(a_val) <= $signed(b_val)};
      rvx_pkg::ACT_GT:       alu_val = {63'd0, $signed(a_val) > $signed(b_val)};
      rvx_pkg::ACT_EQ:       alu_val = {63'd0, a_val == b_val};
      rvx_pkg::ACT_NE:       alu_val = {63'd0, a_val != b_val};
      rvx_pkg::ACT_AND:      alu_val = {63'd0, a_val[0] & b_val[0]};
      rvx_pkg::ACT_OR:       alu_val = {63'd0, a_val[0] | b_val[0]};
      rvx_pkg::ACT_DEC:      alu_val = a_val - 64'd1;
      default:               alu_val = '0;
    endcase
  end

  assign frame_ok = (32'(op.fsel) < 32'(depth)) && op.lidx_ok;
  assign call_ok  = 32'(depth) < FRAMES;
  assign lslot    = LAW'(32'(op.fsel) * LOCALS + 32'(op.lidx));

  always_comb begin
    unique case (mul_step)
      2'd0:    begin mul_x = opa[31:0];  mul_y = opb[31:0];  end
      2'd1:    begin mul_x = opa[31:0];  mul_y = opb[63:32]; end
      default: begin mul_x = opa[63:32]; mul_y = opb[31:0];  end
    endcase
  end

  assign prod     = mul_x * mul_y;
  assign acc_next = (mul_step == 2'd0) ? prod : acc + {prod[31:0], 32'd0};

  assign div_start = active && (op.kind == rvx_pkg::K_DIV) && (b_val != '0);

  rvx_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(a_val), .divisor(b_val),
    .res(div_res)
  );

  assign l_we    = sw_wen || (active && op.kind == rvx_pkg::K_LSET && frame_ok);
  assign l_waddr = sw_wen ? lbase + LAW'(sw_slot) : lslot;
  assign l_wdata = (sw_wen && !sw_use) ? '0 : a_val;

  rvx_ram #(.WIDTH(64), .DEPTH(FRAMES * LOCALS)) u_locals (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(lslot), .rdata(l_q)
  );

  assign rs_we = active && (op.kind == rvx_pkg::K_CALL) && call_ok;

  rvx_ram #(.WIDTH(32), .DEPTH(FRAMES)) u_ret_stack (
    .clk(clk), .we(rs_we), .waddr(RSW'(depth)), .wdata(pc + 32'd1),
    .raddr(RSW'(depth - FW'(1))), .rdata(rs_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pc       <= '0;
      depth    <= FW'(1);
      skipping <= 1'b0;
      halted   <= 1'b0;
      o_valid  <= 1'b0;
      sw_wen   <= 1'b0;
    end else begin
      sw_wen <= 1'b0;
      if (o_valid && rsp.ready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            op    <= q_op;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          opa      <= a_val;
          opb      <= b_val;
          r_npc    <= pc + 32'd1;
          r_status <= rvx_pkg::ST_OK;
          r_val    <= '0;
          r_wr     <= 1'b0;
          r_sout   <= '0;
          state    <= S_DONE;
          if (halted) begin
            r_npc    <= pc;
            r_status <= rvx_pkg::ST_HALTED;
          end else if (skipping) begin
            if (op.kind == rvx_pkg::K_FEND) begin
              skipping <= 1'b0;
            end
          end else begin
            unique case (op.kind)
              rvx_pkg::K_ALU: begin
                r_val <= alu_val;
                r_wr  <= 1'b1;
              end
              rvx_pkg::K_MUL: begin
                mul_step <= 2'd0;
                state    <= S_MUL;
              end
              rvx_pkg::K_DIV: begin
                if (b_val == '0) begin
                  r_status <= rvx_pkg::ST_DIVZERO;
                  r_npc    <= pc;
                end else begin
                  state <= S_DIV;
                end
              end
              rvx_pkg::K_CALL: begin
                if (!call_ok) begin
                  r_status <= rvx_pkg::ST_CALLOVF;
                  r_npc    <= pc;
                end else begin
                  depth <= depth + FW'(1);
                  lbase <= LAW'(32'(depth) * LOCALS);
                  cnt   <= '0;
                  r_npc <= op.target;
                  state <= S_CALL;
                end
              end
              rvx_pkg::K_RET: begin
                if (depth <= FW'(1)) begin
                  r_status <= rvx_pkg::ST_RETUNF;
                  r_npc    <= pc;
                end else begin
                  depth <= depth - FW'(1);
                  state <= S_RET;
                end
              end
              rvx_pkg::K_HALT: begin
                halted   <= 1'b1;
                r_status <= rvx_pkg::ST_HALTED;
                r_npc    <= pc;
              end
              rvx_pkg::K_JUMP: begin
                r_npc <= op.target;
              end
              rvx_pkg::K_BRT: begin
                if (a_val[0]) begin
                  r_npc <= op.target;
                end
              end
              rvx_pkg::K_BRF: begin
                if (!a_val[0]) begin
                  r_npc <= op.target;
                end
              end
              rvx_pkg::K_FBEGIN: begin
                skipping <= 1'b1;
              end
              rvx_pkg::K_FEND, rvx_pkg::K_NOP: begin
              end
              rvx_pkg::K_LGET: begin
                if (!frame_ok) begin
                  r_status <= rvx_pkg::ST_BADFRAME;
                  r_npc    <= pc;
                end else begin
                  state <= S_LGET;
                end
              end
              rvx_pkg::K_LSET: begin
                if (!frame_ok) begin
                  r_status <= rvx_pkg::ST_BADFRAME;
                  r_npc    <= pc;
                end
              end
              rvx_pkg::K_EXT: begin
                r_status <= rvx_pkg::ST_EXTCALL;
                r_sout   <= op.svc;
              end
              default: begin
                r_status <= rvx_pkg::ST_UNSUP;
                r_npc    <= pc;
              end
            endcase
          end
        end
        S_MUL: begin
          acc      <= acc_next;
          mul_step <= mul_step + 2'd1;
          if (mul_step == 2'd2) begin
            r_val <= acc_next;
            r_wr  <= 1'b1;
            state <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            r_val <= (op.action == rvx_pkg::ACT_DIV) ? div_res.quo : div_res.rem;
            r_wr  <= 1'b1;
            state <= S_DONE;
          end
        end
        S_CALL: begin
          if (32'(cnt) < LOCALS) begin
            sw_wen  <= 1'b1;
            sw_slot <= cnt;
            sw_use  <= 32'(cnt) < 32'(op.argn);
            cnt     <= cnt + CW'(1);
          end else begin
            state <= S_DONE;
          end
        end
        S_RET: begin
          r_npc <= rs_q;
          state <= S_DONE;
        end
        S_LGET: begin
          r_val <= l_q;
          r_wr  <= 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (commit_ok) begin
            pc       <= r_npc;
            o_valid  <= 1'b1;
            o_npc    <= r_npc;
            o_status <= r_status;
            o_val    <= r_val;
            o_wr     <= r_wr;
            o_sout   <= r_sout;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid          = o_valid;
  assign rsp.next_pc        = o_npc;
  assign rsp.status         = o_status;
  assign rsp.result_value   = o_val;
  assign rsp.result_written = o_wr;
  assign rsp.service_out    = o_sout;

endmodule

`default_nettype wire

// ----- hw/rtl/register_vm_execute_unit.sv -----
// ----------------------------------------------------------------------------
// register_vm_execute_unit
// Executes decoded bytecode instructions of a register VM: program counter,
// register file, local frames, return stack and the constant-base register.
// ----------------------------------------------------------------------------
//   Channel  Kind      Direction  Payload
//   req      valid/rdy in         action, registers, immediate, target, locals
//   rsp      valid/rdy out        next_pc, status, result, written, service
//   APB      psel/pen  in/out     const_base at byte address 0
//
// Most instructions pass through queue pop with register-file read, execute
// and commit. Return and local get add a state for the memory read. Multiply
// steps through one 32x32 multiplier, divide and modulo wait on the
// bit-serial divider, and a call sweeps the new frame through the locals
// memory port.
// Reset is synchronous; the register file reads zero until written.
// A stalled result holds in the output register while up to two further
// words wait in the queue.
`default_nettype none

module register_vm_execute_unit #(
  parameter int REGS   = rvx_pkg::REGS_DEF,
  parameter int LOCALS = rvx_pkg::LOCALS_DEF,
  parameter int FRAMES = rvx_pkg::FRAMES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  rvx_req_if.sink                         req,
  rvx_rsp_if.source                       rsp,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rvx_pkg::CFG_AW-1:0] paddr,
  input  wire logic [63:0]                pwdata,
  output      logic [63:0]                prdata,
  output      logic                       pready
);

  logic [63:0]  const_base;
  logic         q_full;
  logic         q_push;
  rvx_pkg::op_t q_push_op;
  logic         q_pop;
  logic         q_valid;
  rvx_pkg::op_t q_head;

  assign pready = 1'b1;
  assign prdata = (paddr == '0) ? const_base : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      const_base <= '0;
    end else if (psel && penable && pwrite && paddr == '0) begin
      const_base <= pwdata;
    end
  end

  rvx_front #(.REGS(REGS), .LOCALS(LOCALS)) u_front (
    .req(req), .full(q_full), .push(q_push), .push_op(q_push_op)
  );

  rvx_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_op(q_push_op), .full(q_full),
    .pop(q_pop), .not_empty(q_valid), .head_op(q_head)
  );

  rvx_back #(.REGS(REGS), .LOCALS(LOCALS), .FRAMES(FRAMES)) u_back (
    .clk(clk), .rst(rst), .const_base(const_base), .q_valid(q_valid),
    .q_op(q_head), .q_pop(q_pop), .rsp(rsp)
  );

endmodule

`default_nettype wire
